### rtl/wsrm_pkg.sv
// ----------------------------------------------------------------------------
// wsrm_pkg
// shared types and constants for the dot-star pattern matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsrm_pkg;

  localparam int unsigned MAX_TOKENS_DEF = 16;
  localparam int unsigned IN_TDATA_W     = 24;
  localparam int unsigned OUT_TDATA_W    = 8;

  localparam logic [7:0] DOT_CHAR = 8'd46;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // write control for the token store
  typedef struct packed {
    logic       clear;
    logic       append;
    logic [7:0] chr;
    logic       star;
  } tok_wr_t;

endpackage

### rtl/wsrm_tok_store.sv
// ----------------------------------------------------------------------------
// wsrm_tok_store
// pattern token registers, one entry per position, appended at the fill count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsrm_tok_store #(
  parameter int unsigned MAX_TOKENS = wsrm_pkg::MAX_TOKENS_DEF,
  parameter int unsigned CW         = $clog2(MAX_TOKENS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wsrm_pkg::tok_wr_t wr,
  input  logic [CW-1:0]     count,
  output logic [7:0]        tok_chars [MAX_TOKENS],
  output logic [MAX_TOKENS-1:0] tok_stars
);
  import wsrm_pkg::*;

  logic [7:0]            chars_r [MAX_TOKENS];
  logic [MAX_TOKENS-1:0] stars_r;

  for (genvar g = 0; g < MAX_TOKENS; g++) begin : g_entry
    always_ff @(posedge clk) begin
      if (rst_n && wr.append && !wr.clear && count == CW'(g)) begin
        chars_r[g] <= wr.chr;
        stars_r[g] <= wr.star;
      end
    end
    assign tok_chars[g] = chars_r[g];
  end

  assign tok_stars = stars_r;

endmodule

### rtl/wsrm_step.sv
// ----------------------------------------------------------------------------
// wsrm_step
// position-set update: one text character step plus closure over starred tokens
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsrm_step #(
  parameter int unsigned MAX_TOKENS = wsrm_pkg::MAX_TOKENS_DEF,
  parameter int unsigned CW         = $clog2(MAX_TOKENS + 1)
) (
  input  logic [7:0]            tok_chars [MAX_TOKENS],
  input  logic [MAX_TOKENS-1:0] tok_stars,
  input  logic [CW-1:0]         count,
  input  logic [MAX_TOKENS:0]   active,
  input  logic                  fresh,
  input  logic [7:0]            text_char,
  output logic [MAX_TOKENS:0]   active_step,
  output logic [MAX_TOKENS:0]   active_now,
  output logic                  hit
);
  import wsrm_pkg::*;

  function automatic logic [MAX_TOKENS:0] closure(
    input logic [MAX_TOKENS:0]   s_in,
    input logic [MAX_TOKENS-1:0] stars,
    input logic [CW-1:0]         cnt
  );
    logic [MAX_TOKENS:0] s;
    s = s_in;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (CW'(i) < cnt && s[i] && stars[i]) begin
        s[i+1] = 1'b1;
      end
    end
    return s;
  endfunction

  logic [MAX_TOKENS:0] start_set;
  logic [MAX_TOKENS:0] moved;

  always_comb begin
    start_set  = closure({{MAX_TOKENS{1'b0}}, 1'b1}, tok_stars, count);
    active_now = fresh ? start_set : active;
    moved      = '0;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (CW'(i) < count && active_now[i] &&
          (tok_chars[i] == DOT_CHAR || tok_chars[i] == text_char)) begin
        if (tok_stars[i]) begin
          moved[i] = 1'b1;
        end else begin
          moved[i+1] = 1'b1;
        end
      end
    end
    active_step = closure(moved, tok_stars, count);
    hit         = active_now[count];
  end

endmodule

### rtl/wildcard_star_regex_matcher_unit.sv
// ----------------------------------------------------------------------------
// wildcard_star_regex_matcher_unit
// whole-string matcher for literal, '.' and starred tokens
// ----------------------------------------------------------------------------
// usage: every input beat carries an opcode in in_tuser. clear empties the
// pattern, append adds one token (character plus star flag), text feeds one
// subject character and end of text closes the string. only end of text
// gives an output beat: matched and the pattern overflow flag. appending
// more than MAX_TOKENS tokens drops the extra ones, sets the overflow flag
// and forces matched low until the next clear.
// timing: a beat lands in an input register, is processed from there by the
// position update logic and its result is written into the output register,
// where it is offered on out_tdata. one beat per cycle is sustained while no
// end of text waits on a full output register; the position update with its
// ripple through starred tokens is combinational.
// stalls: while a result waits in the output register the block still takes
// clear, append and text beats; only a further end of text waits, and
// in_tready drops until out_tready frees the register.
// reset: synchronous rst_n empties the pattern, clears overflow and the
// output valid flag; the token store itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wildcard_star_regex_matcher_unit #(
  parameter int unsigned MAX_TOKENS = wsrm_pkg::MAX_TOKENS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] token_char, [8] token_star, [16:9] text_char, [23:17] zero
  input  logic [wsrm_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] opcode
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] matched, [1] pattern_overflow, [7:2] zero
  output logic [wsrm_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import wsrm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_TOKENS + 1);

  // input register
  logic       item_vld_r, item_vld_nxt;
  op_t        op_r;
  logic [7:0] tchar_r;
  logic       tstar_r;
  logic [7:0] xchar_r;

  // matcher state
  logic [CW-1:0]       count_r, count_nxt;
  logic [MAX_TOKENS:0] active_r, active_nxt;
  logic                fresh_r, fresh_nxt;
  logic                ovf_r, ovf_nxt;

  // output register
  logic       res_vld_r, res_vld_nxt;
  logic       res_match_r, res_match_nxt;
  logic       res_ovf_r, res_ovf_nxt;

  logic                  out_free;
  logic                  advance;
  logic                  in_take;
  tok_wr_t               tok_wr;
  logic [7:0]            tok_chars [MAX_TOKENS];
  logic [MAX_TOKENS-1:0] tok_stars;
  logic [MAX_TOKENS:0]   active_step;
  logic [MAX_TOKENS:0]   active_now;
  logic                  hit;

  assign out_free  = !res_vld_r || out_tready;
  assign advance   = item_vld_r && (op_r != OP_END || out_free);
  assign in_tready = !item_vld_r || advance;
  assign in_take   = in_tvalid && in_tready;

  assign tok_wr.clear  = advance && op_r == OP_CLEAR;
  assign tok_wr.append = advance && op_r == OP_APPEND && count_r < CW'(MAX_TOKENS);
  assign tok_wr.chr    = tchar_r;
  assign tok_wr.star   = tstar_r;

  wsrm_tok_store #(
    .MAX_TOKENS (MAX_TOKENS),
    .CW         (CW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (tok_wr),
    .count     (count_r),
    .tok_chars (tok_chars),
    .tok_stars (tok_stars)
  );

  wsrm_step #(
    .MAX_TOKENS (MAX_TOKENS),
    .CW         (CW)
  ) u_step (
    .tok_chars   (tok_chars),
    .tok_stars   (tok_stars),
    .count       (count_r),
    .active      (active_r),
    .fresh       (fresh_r),
    .text_char   (xchar_r),
    .active_step (active_step),
    .active_now  (active_now),
    .hit         (hit)
  );

  always_comb begin
    item_vld_nxt  = in_take || (item_vld_r && !advance);
    count_nxt     = count_r;
    active_nxt    = active_r;
    fresh_nxt     = fresh_r;
    ovf_nxt       = ovf_r;
    res_vld_nxt   = res_vld_r && !out_tready;
    res_match_nxt = res_match_r;
    res_ovf_nxt   = res_ovf_r;
    if (advance) begin
      case (op_r)
        OP_CLEAR: begin
          count_nxt  = '0;
          ovf_nxt    = 1'b0;
          fresh_nxt  = 1'b1;
          active_nxt = '0;
        end
        OP_APPEND: begin
          if (count_r < CW'(MAX_TOKENS)) begin
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          fresh_nxt = 1'b1;
        end
        OP_TEXT: begin
          active_nxt = active_step;
          fresh_nxt  = 1'b0;
        end
        OP_END: begin
          active_nxt    = active_now;
          fresh_nxt     = 1'b1;
          res_vld_nxt   = 1'b1;
          res_match_nxt = hit && !ovf_r;
          res_ovf_nxt   = ovf_r;
        end
        default: begin
          fresh_nxt = fresh_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      count_r    <= '0;
      active_r   <= '0;
      fresh_r    <= 1'b1;
      ovf_r      <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      count_r    <= count_nxt;
      active_r   <= active_nxt;
      fresh_r    <= fresh_nxt;
      ovf_r      <= ovf_nxt;
      res_vld_r  <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r    <= op_t'(in_tuser);
      tchar_r <= in_tdata[7:0];
      tstar_r <= in_tdata[8];
      xchar_r <= in_tdata[16:9];
    end
    res_match_r <= res_match_nxt;
    res_ovf_r   <= res_ovf_nxt;
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, res_ovf_r, res_match_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TOKENS))
    else $error("token count beyond store depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == CW'(MAX_TOKENS))
    else $error("overflow flag set with store not full");

  a_match_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && res_match_r |-> !res_ovf_r)
    else $error("match reported with overflow");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> item_vld_r && op_r == OP_END && res_vld_r && !out_tready)
    else $error("input stalled without a blocked end of text");

  a_clear_effect: assert property (@(posedge clk) disable iff (!rst_n)
    advance && op_r == OP_CLEAR |=> count_r == '0 && !ovf_r && fresh_r)
    else $error("clear did not empty the pattern");
`endif

endmodule
